[sv/priority_ordered_slot_table_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the priority ordered slot table.
// Each macro builds one labeled concurrent assertion, clocked on i_clk and
// disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_ORDERED_SLOT_TABLE_UNIT_ASSERT_SVH
`define PRIORITY_ORDERED_SLOT_TABLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define POST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("slot table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define POST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("slot table assertion failed");

`endif

[sv/post_pkg.sv]
// ---------------------------------------------------------------------------
// post_pkg
// Types, constants and helpers used by the slot table unit.
// ---------------------------------------------------------------------------
package post_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int EXT_W         = CNT_W + 6;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One request.
    typedef struct packed {
        logic        command;
        logic [15:0] entry_priority;
        logic [15:0] entry_tag;
        logic [5:0]  slot_index;
    } t_req;

    // One response.
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot;
        logic [5:0] moved_count;
    } t_rsp;

    // One stored table entry.
    typedef struct packed {
        logic [15:0] prio;
        logic [15:0] tag;
    } t_entry;

    // Low six bits of a slot number.
    function automatic logic [5:0] f_low6(input logic [CNT_W-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[5:0];
    endfunction

    // Count clipped to the six bit response field.
    function automatic logic [5:0] f_sat6(input logic [CNT_W-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return (w > EXT_W'(63)) ? 6'd63 : w[5:0];
    endfunction

endpackage

[sv/post_ram.sv]
// ---------------------------------------------------------------------------
// post_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module post_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/priority_ordered_slot_table_unit.sv]
// ---------------------------------------------------------------------------
// priority_ordered_slot_table_unit
// Slot table kept packed from slot 0 in descending priority order.
// ---------------------------------------------------------------------------
// Usage: a request (i_req_valid / o_req_ready) carries an insert or a delete.
// An insert walks the table from slot 0 to the first entry of strictly lower
// priority, moves the entries from there to the end of the table down by one
// and writes the new entry. A delete moves the entries after the slot up by
// one. Every request gives one response (o_rsp_valid / i_rsp_ready) with a
// status, the slot touched and the number of entries moved.
// Structure: the entries live in one RAM with a single read and a single
// write port, and one pointer sequencer reads one entry per cycle. A full
// table or a delete of an empty slot skips the walk and the moves. The
// response goes to an output register once that register is free. A new
// request is taken only while the sequencer is idle; a finished response may
// wait in the output register meanwhile.
// Reset empties the table at once (fill count to zero); no clearing pass.
// If the receiver stalls, the next finished request waits until it drains.
// ---------------------------------------------------------------------------
module priority_ordered_slot_table_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  post_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output post_pkg::t_rsp o_rsp
);

    localparam int CW = post_pkg::CNT_W;
    localparam int AW = post_pkg::ADDR_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_SHDN = 3'd2;
    localparam logic [2:0] S_SHUP = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);
    localparam logic [CW-1:0] FULL = CW'(post_pkg::TABLE_ENTRIES);

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_wr, n_wr;
    logic [CW-1:0]        r_pos, n_pos;
    logic [15:0]          r_prio, n_prio;
    logic [15:0]          r_tag, n_tag;
    post_pkg::t_rsp       r_res, n_res;
    post_pkg::t_rsp       r_rsp, n_rsp;
    logic                 r_rsp_valid, n_rsp_valid;

    logic [CW-1:0]        rd_addr;
    logic [CW-1:0]        wr_addr;
    logic                 wr_en;
    post_pkg::t_entry     wr_data;
    post_pkg::t_entry     rd_data;
    logic                 req_acc;
    logic [CW-1:0]        del_idx;
    logic                 del_miss;
    logic                 hit;
    logic                 last;
    logic                 ins_full;
    logic                 full_rsp;

    // Entry storage.
    post_ram #(
        .WIDTH ($bits(post_pkg::t_entry)),
        .DEPTH (post_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Delete target and range check against the fill count.
    assign del_idx  = CW'(i_req.slot_index);
    assign del_miss = (post_pkg::EXT_W'(i_req.slot_index) >= post_pkg::EXT_W'(r_count));

    // Walk compare: stop at the first stored entry of strictly lower priority.
    assign hit  = (rd_data.prio < r_prio);
    assign last = (CW'(r_idx + ONE) == r_count);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_pos       = r_pos;
        n_prio      = r_prio;
        n_tag       = r_tag;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        rd_addr     = '0;
        wr_addr     = r_wr;
        wr_en       = 1'b0;
        wr_data     = rd_data;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.command == post_pkg::CMD_DELETE) begin
                    rd_addr = CW'(del_idx + ONE);
                end
                if (req_acc) begin
                    n_prio = i_req.entry_priority;
                    n_tag  = i_req.entry_tag;
                    if (i_req.command == post_pkg::CMD_INSERT) begin
                        if (r_count == FULL) begin
                            n_res   = '{status: post_pkg::ST_FULL, slot: 6'd0,
                                       moved_count: 6'd0};
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            n_pos   = '0;
                            n_res   = '{status: post_pkg::ST_DONE, slot: 6'd0,
                                       moved_count: 6'd0};
                            n_state = S_PUT;
                        end else begin
                            n_idx   = '0;
                            n_state = S_FIND;
                        end
                    end else begin
                        if (del_miss) begin
                            n_res   = '{status: post_pkg::ST_EMPTY,
                                       slot: i_req.slot_index, moved_count: 6'd0};
                            n_state = S_DONE;
                        end else if (CW'(del_idx + ONE) == r_count) begin
                            n_count = CW'(r_count - ONE);
                            n_res   = '{status: post_pkg::ST_DONE,
                                       slot: i_req.slot_index, moved_count: 6'd0};
                            n_state = S_DONE;
                        end else begin
                            n_wr    = del_idx;
                            n_res   = '{status: post_pkg::ST_DONE,
                                       slot: i_req.slot_index,
                                       moved_count: post_pkg::f_sat6(
                                           CW'(r_count - ONE - del_idx))};
                            n_state = S_SHUP;
                        end
                    end
                end
            end

            // One stored entry compared per cycle.
            S_FIND: begin
                if (hit) begin
                    n_pos   = r_idx;
                    n_wr    = r_count;
                    rd_addr = CW'(r_count - ONE);
                    n_res   = '{status: post_pkg::ST_DONE,
                               slot: post_pkg::f_low6(r_idx),
                               moved_count: post_pkg::f_sat6(CW'(r_count - r_idx))};
                    n_state = S_SHDN;
                end else if (last) begin
                    n_pos   = r_count;
                    n_res   = '{status: post_pkg::ST_DONE,
                               slot: post_pkg::f_low6(r_count), moved_count: 6'd0};
                    n_state = S_PUT;
                end else begin
                    n_idx   = CW'(r_idx + ONE);
                    rd_addr = CW'(r_idx + ONE);
                end
            end

            // Move entries down one slot, from the end toward the insert point.
            S_SHDN: begin
                wr_en = 1'b1;
                if (r_wr == CW'(r_pos + ONE)) begin
                    n_state = S_PUT;
                end else begin
                    n_wr    = CW'(r_wr - ONE);
                    rd_addr = CW'(r_wr - TWO);
                end
            end

            // Move entries up one slot, from the deleted slot toward the end.
            S_SHUP: begin
                wr_en = 1'b1;
                if (CW'(r_wr + TWO) == r_count) begin
                    n_count = CW'(r_count - ONE);
                    n_state = S_DONE;
                end else begin
                    n_wr    = CW'(r_wr + ONE);
                    rd_addr = CW'(r_wr + TWO);
                end
            end

            // Write the new entry at the insert point.
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = '{prio: r_prio, tag: r_tag};
                n_count = CW'(r_count + ONE);
                n_state = S_DONE;
            end

            // Hand the response to the output register once it is free.
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_wr   <= n_wr;
        r_pos  <= n_pos;
        r_prio <= n_prio;
        r_tag  <= n_tag;
        r_res  <= n_res;
        r_rsp  <= n_rsp;
    end

    // Terms used by the checks below.
    assign ins_full = req_acc && (i_req.command == post_pkg::CMD_INSERT) && (r_count == FULL);
    assign full_rsp = (r_state == S_DONE) && (r_res.status == post_pkg::ST_FULL);

    `include "priority_ordered_slot_table_unit_assert.svh"

    // The fill count never exceeds the table size.
    `POST_ASSERT_SAME(a_count_range, 1'b1, r_count <= FULL)
    // An insert into a full table answers with the full status.
    `POST_ASSERT_NEXT(a_full_insert, ins_full, full_rsp)
    // While moving entries down, the write pointer stays above the insert point.
    `POST_ASSERT_SAME(a_shdn_order, r_state == S_SHDN, r_wr > r_pos)
    // A request changes the fill count by at most one.
    `POST_ASSERT_NEXT(a_count_step, r_state != S_IDLE, CW'(r_count - $past(r_count) + ONE) <= TWO)

endmodule
